// ===== rtl/sths_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sths_pkg
// Shared types, codes and byte tables for the styled text HTML serializer.
// ----------------------------------------------------------------------------
package sths_pkg;

  // input operation codes
  localparam logic [1:0] OP_TEXT  = 2'd0;
  localparam logic [1:0] OP_STYLE = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // style flag bits
  localparam int STY_BOLD   = 0;
  localparam int STY_ITALIC = 1;
  localparam int STY_STRIKE = 2;

  // segment indexes, in emission order
  localparam logic [2:0] SEG_CLOSE_S = 3'd0;
  localparam logic [2:0] SEG_CLOSE_I = 3'd1;
  localparam logic [2:0] SEG_CLOSE_B = 3'd2;
  localparam logic [2:0] SEG_OPEN_B  = 3'd3;
  localparam logic [2:0] SEG_OPEN_I  = 3'd4;
  localparam logic [2:0] SEG_OPEN_S  = 3'd5;
  localparam logic [2:0] SEG_CHAR    = 3'd6;
  localparam int         NUM_SEGS    = 7;

  // character kinds
  localparam logic [1:0] CK_PLAIN = 2'd0;
  localparam logic [1:0] CK_LT    = 2'd1;
  localparam logic [1:0] CK_GT    = 2'd2;
  localparam logic [1:0] CK_AMP   = 2'd3;

  // ascii bytes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;

  // job queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // one classified item: segments to emit plus the text byte
  typedef struct packed {
    logic [NUM_SEGS-1:0] segs;
    logic [1:0]          ckind;
    logic [7:0]          ch;
  } job_t;

  // lowest pending segment
  function automatic logic [2:0] first_seg(input logic [NUM_SEGS-1:0] mask);
    logic [2:0] idx;
    idx = SEG_CHAR;
    for (int k = NUM_SEGS - 1; k >= 0; k--) begin
      if (mask[k]) begin
        idx = 3'(k);
      end
    end
    return idx;
  endfunction

  // number of bytes in a segment
  function automatic logic [2:0] seg_len(input logic [2:0] seg, input logic [1:0] ckind);
    logic [2:0] len;
    case (seg)
      SEG_CLOSE_S, SEG_CLOSE_I, SEG_CLOSE_B: len = 3'd4;
      SEG_OPEN_B, SEG_OPEN_I, SEG_OPEN_S:    len = 3'd3;
      SEG_CHAR: begin
        case (ckind)
          CK_PLAIN: len = 3'd1;
          CK_AMP:   len = 3'd5;
          default:  len = 3'd4;
        endcase
      end
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  // byte at an offset within a segment
  function automatic logic [7:0] seg_byte(input logic [2:0] seg, input logic [2:0] off,
                                          input logic [1:0] ckind, input logic [7:0] ch);
    logic [7:0] letter;
    logic [7:0] b;
    case (seg)
      SEG_CLOSE_S, SEG_OPEN_S: letter = CH_S;
      SEG_CLOSE_I, SEG_OPEN_I: letter = CH_I;
      default:                 letter = CH_B;
    endcase
    b = ch;
    case (seg)
      SEG_CLOSE_S, SEG_CLOSE_I, SEG_CLOSE_B: begin
        case (off)
          3'd0:    b = CH_LT;
          3'd1:    b = CH_SLASH;
          3'd2:    b = letter;
          default: b = CH_GT;
        endcase
      end
      SEG_OPEN_B, SEG_OPEN_I, SEG_OPEN_S: begin
        case (off)
          3'd0:    b = CH_LT;
          3'd1:    b = letter;
          default: b = CH_GT;
        endcase
      end
      default: begin
        case (ckind)
          CK_LT: begin
            case (off)
              3'd0:    b = CH_AMP;
              3'd1:    b = CH_L;
              3'd2:    b = CH_T;
              default: b = CH_SEMI;
            endcase
          end
          CK_GT: begin
            case (off)
              3'd0:    b = CH_AMP;
              3'd1:    b = CH_G;
              3'd2:    b = CH_T;
              default: b = CH_SEMI;
            endcase
          end
          CK_AMP: begin
            case (off)
              3'd0:    b = CH_AMP;
              3'd1:    b = CH_A;
              3'd2:    b = CH_M;
              3'd3:    b = CH_P;
              default: b = CH_SEMI;
            endcase
          end
          default: b = ch;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sths_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sths_front
// Accepts input words, tracks the open style and turns each word that emits bytes into a job.
// ----------------------------------------------------------------------------
module sths_front import sths_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_char,
  input  wire logic [2:0] in_style,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [2:0] cur_style_r, cur_style_nxt;
  logic [2:0] target;
  logic [2:0] dropped;
  logic [2:0] added;
  logic       is_text;
  logic       known_op;
  logic       accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // classify the word
  always_comb begin
    is_text  = (in_op == OP_TEXT);
    known_op = (in_op == OP_TEXT) || (in_op == OP_STYLE) || (in_op == OP_END);
    target   = (in_op == OP_END) ? 3'd0 : in_style;
    dropped  = known_op ? (cur_style_r & ~target) : 3'd0;
    added    = known_op ? (~cur_style_r & target) : 3'd0;

    q_job.segs[SEG_CLOSE_S] = dropped[STY_STRIKE];
    q_job.segs[SEG_CLOSE_I] = dropped[STY_ITALIC];
    q_job.segs[SEG_CLOSE_B] = dropped[STY_BOLD];
    q_job.segs[SEG_OPEN_B]  = added[STY_BOLD];
    q_job.segs[SEG_OPEN_I]  = added[STY_ITALIC];
    q_job.segs[SEG_OPEN_S]  = added[STY_STRIKE];
    q_job.segs[SEG_CHAR]    = is_text;

    case (in_char)
      CH_LT:   q_job.ckind = CK_LT;
      CH_GT:   q_job.ckind = CK_GT;
      CH_AMP:  q_job.ckind = CK_AMP;
      default: q_job.ckind = CK_PLAIN;
    endcase
    q_job.ch = in_char;

    q_push = accept && (q_job.segs != '0);
  end

  // style tracking
  always_comb begin
    cur_style_nxt = cur_style_r;
    if (accept && known_op) begin
      cur_style_nxt = target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_style_r <= 3'd0;
    end else begin
      cur_style_r <= cur_style_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sths_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sths_queue
// Small show-ahead job queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module sths_queue import sths_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sths_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sths_back
// Walks the head job segment by segment, one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sths_back import sths_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire job_t       head_job,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [NUM_SEGS-1:0] done_r, done_nxt;
  logic [2:0]          off_r, off_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  logic [NUM_SEGS-1:0] remain;
  logic [NUM_SEGS-1:0] cur_oh;
  logic [2:0]          cur_seg;
  logic [2:0]          cur_len;
  logic                seg_end;
  logic                last_byte;
  logic                emit;
  logic [7:0]          emit_byte;

  // current segment and byte
  always_comb begin
    remain    = head_job.segs & ~done_r;
    cur_seg   = first_seg(remain);
    cur_oh    = NUM_SEGS'(1) << cur_seg;
    cur_len   = seg_len(cur_seg, head_job.ckind);
    seg_end   = (off_r == cur_len - 3'd1);
    last_byte = seg_end && ((remain & ~cur_oh) == '0);
    emit_byte = seg_byte(cur_seg, off_r, head_job.ckind, head_job.ch);
    emit      = head_valid && (!out_valid_r || out_tready);
    pop       = emit && last_byte;
  end

  // position update
  always_comb begin
    done_nxt = done_r;
    off_nxt  = off_r;
    if (emit) begin
      if (last_byte) begin
        done_nxt = '0;
        off_nxt  = 3'd0;
      end else if (seg_end) begin
        done_nxt = done_r | cur_oh;
        off_nxt  = 3'd0;
      end else begin
        off_nxt = off_r + 3'd1;
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      off_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= last_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

`ifndef ASSERT_OFF
  // a queued job always has a segment left to emit
  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (remain != '0))
    else $error("head job has no pending segment");

  // completed segments belong to the head job
  a_done_sub: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ((done_r & ~head_job.segs) == '0))
    else $error("done mask outside head job");

  // offset stays inside the current segment
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (off_r < cur_len))
    else $error("offset beyond segment length");

  // position is clear when no job waits
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (done_r == '0 && off_r == 3'd0))
    else $error("stale position with empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/styled_text_html_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// styled_text_html_serializer
// Styled text bytes in, HTML bytes out with style tags and escaped entities.
// ----------------------------------------------------------------------------
// channel  dir  tdata                         tuser        tlast
// in_      in   [7:0] char_byte [10:8] style  [1:0] op     -
// out_     out  [7:0] out_byte                -            last
//
// output: one byte per cycle while a job waits and out_tready is high; a plain text
//   byte with unchanged style emits one byte, other words up to 17 bytes,
//   all emitted by the back sequencer
// a 4-entry job queue lets the front keep accepting; first byte goes via the queue and the output register
// reset: synchronous, active low; clears the open style, queue and output
// stalls: out_tready low holds the output register and backs up the queue
// ----------------------------------------------------------------------------
module styled_text_html_serializer import sths_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] char_byte, [10:8] style, [15:11] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  // front: classify and track style
  sths_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_char   (in_tdata[7:0]),
    .in_style  (in_tdata[10:8]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // job queue
  sths_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: byte sequencer and output register
  sths_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the styled text HTML serializer: words go in from a
// queue, a local model predicts every emitted HTML byte and its last flag,
// and the output stream is compared in order under random backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import sths_pkg::*;

  localparam int         CLK_HALF     = 4;
  localparam int         RESET_CYCLES = 11;
  localparam int         RANDOM_WORDS = 125;
  localparam int         HOLD_AFTER   = 40;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         TAIL_CYCLES  = 150;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_byte;
    logic [2:0] style;
  } text_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } html_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;  // [7:0] char_byte, [10:8] style, [15:11] zero
  logic [1:0]  in_tuser   = '0;  // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] out_byte
  logic        out_tlast;

  text_word_t  word_pending[$];
  html_byte_t  html_expect[$];
  logic [7:0]  word_bytes[$];
  text_word_t  drive_word;
  logic [2:0]  open_style     = 3'd0;
  logic        in_taken       = 1'b0;
  logic        hold_active    = 1'b0;
  int          errors         = 0;
  int          words_accepted = 0;
  int          cycle_count    = 0;
  logic        calm;

  styled_text_html_serializer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // stretch with no idling on either side
  assign calm = (words_accepted >= 70) && (words_accepted < 110);

  // tag bytes: "<x>" or "</x>"
  task automatic add_tag(input logic closing, input logic [7:0] letter);
    word_bytes.push_back(CH_LT);
    if (closing) begin
      word_bytes.push_back(CH_SLASH);
    end
    word_bytes.push_back(letter);
    word_bytes.push_back(CH_GT);
  endtask

  // text byte with entity escaping
  task automatic add_char(input logic [7:0] ch);
    case (ch)
      CH_LT: begin
        word_bytes.push_back(CH_AMP);
        word_bytes.push_back(CH_L);
        word_bytes.push_back(CH_T);
        word_bytes.push_back(CH_SEMI);
      end
      CH_GT: begin
        word_bytes.push_back(CH_AMP);
        word_bytes.push_back(CH_G);
        word_bytes.push_back(CH_T);
        word_bytes.push_back(CH_SEMI);
      end
      CH_AMP: begin
        word_bytes.push_back(CH_AMP);
        word_bytes.push_back(CH_A);
        word_bytes.push_back(CH_M);
        word_bytes.push_back(CH_P);
        word_bytes.push_back(CH_SEMI);
      end
      default: word_bytes.push_back(ch);
    endcase
  endtask

  // html bytes caused by one accepted word, queued in emission order
  task automatic predict_html(input text_word_t w);
    logic [2:0] target;
    target = (w.op == OP_END) ? 3'd0 : w.style;
    word_bytes.delete();
    if (w.op != OP_UNUSED) begin
      // close dropped styles innermost first, then open added ones
      if (open_style[STY_STRIKE] && !target[STY_STRIKE]) add_tag(1'b1, CH_S);
      if (open_style[STY_ITALIC] && !target[STY_ITALIC]) add_tag(1'b1, CH_I);
      if (open_style[STY_BOLD] && !target[STY_BOLD])     add_tag(1'b1, CH_B);
      if (!open_style[STY_BOLD] && target[STY_BOLD])     add_tag(1'b0, CH_B);
      if (!open_style[STY_ITALIC] && target[STY_ITALIC]) add_tag(1'b0, CH_I);
      if (!open_style[STY_STRIKE] && target[STY_STRIKE]) add_tag(1'b0, CH_S);
      open_style = target;
      if (w.op == OP_TEXT) begin
        add_char(w.char_byte);
      end
    end
    foreach (word_bytes[k]) begin
      html_expect.push_back('{out_byte: word_bytes[k], last: (k == word_bytes.size() - 1)});
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got_v, want_v, cycle_count);
    errors++;
  endtask

  task automatic add_word(input logic [1:0] op, input logic [7:0] ch, input logic [2:0] style);
    word_pending.push_back('{op: op, char_byte: ch, style: style});
  endtask

  // input driver, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (word_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
        drive_word = word_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {5'd0, drive_word.style, drive_word.char_byte};
        in_tuser  <= drive_word.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_active && (calm || $urandom_range(0, 99) >= 25);
    end
  end

  // accept words into the model, check emitted bytes
  always @(posedge clk) begin
    html_byte_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        words_accepted++;
        predict_html('{op: in_tuser, char_byte: in_tdata[7:0], style: in_tdata[10:8]});
      end
      if (out_tvalid && out_tready) begin
        if (html_expect.size() == 0) begin
          report_mismatch("unexpected byte", out_tdata, 8'h00);
        end else begin
          want = html_expect.pop_front();
          if (out_tdata !== want.out_byte) begin
            report_mismatch("out_byte", out_tdata, want.out_byte);
          end
          if (out_tlast !== want.last) begin
            report_mismatch("last", {7'd0, out_tlast}, {7'd0, want.last});
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("styled_text_html_serializer test failed");
      $finish;
    end
  end

  // long receiver hold-off so the job queue fills and the input stalls
  initial begin
    wait (words_accepted >= HOLD_AFTER);
    @(negedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active <= 1'b0;
  end

  // stimulus and end of run
  initial begin
    int         counted;
    int         roll;
    logic [2:0] run_style;
    logic [7:0] ch;

    // directed words
    add_word(OP_TEXT, 8'h61, 3'd0);     // plain byte, no style
    add_word(OP_TEXT, CH_LT, 3'd1);     // open bold, escaped less-than
    add_word(OP_TEXT, CH_GT, 3'd3);     // add italic, escaped greater-than
    add_word(OP_TEXT, CH_AMP, 3'd7);    // add strike, escaped ampersand
    add_word(OP_TEXT, 8'hFF, 3'd7);     // unchanged style, top byte
    add_word(OP_TEXT, 8'h00, 3'd0);     // close all three, zero byte
    add_word(OP_STYLE, 8'hA5, 3'd0);    // style word with unchanged style
    add_word(OP_STYLE, 8'h5A, 3'd7);    // open all three without text
    add_word(OP_END, 8'hFF, 3'd7);      // close everything
    add_word(OP_END, 8'h3C, 3'd5);      // end with nothing open
    add_word(OP_UNUSED, 8'hFF, 3'd7);   // unused op
    add_word(OP_TEXT, 8'h7A, 3'd5);     // bold and strike
    add_word(OP_UNUSED, 8'h00, 3'd0);   // unused op leaves style open
    add_word(OP_TEXT, CH_AMP, 3'd2);    // drop strike and bold, add italic
    add_word(OP_STYLE, 8'h00, 3'd4);    // italic to strike
    add_word(OP_TEXT, 8'h80, 3'd3);     // strike to bold italic
    add_word(OP_TEXT, CH_LT, 3'd6);     // bold to strike
    add_word(OP_STYLE, 8'h00, 3'd1);
    add_word(OP_TEXT, CH_GT, 3'd1);
    add_word(OP_END, 8'h00, 3'd0);
    add_word(OP_TEXT, 8'h7F, 3'd4);
    add_word(OP_STYLE, 8'hFF, 3'd0);
    add_word(OP_END, 8'h26, 3'd2);

    // random text runs with style changes, ends and some noise
    counted   = 0;
    run_style = 3'd0;
    while (counted < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        add_word(OP_UNUSED, 8'($urandom), 3'($urandom));
      end else begin
        counted++;
        if (roll < 9) begin
          add_word(OP_END, 8'($urandom), 3'($urandom));
          run_style = 3'd0;
        end else if (roll < 18) begin
          run_style = 3'($urandom_range(0, 7));
          add_word(OP_STYLE, 8'($urandom), run_style);
        end else begin
          if ($urandom_range(0, 99) < 15) begin
            run_style = 3'($urandom_range(0, 7));
          end
          case ($urandom_range(0, 9))
            0:       ch = CH_LT;
            1:       ch = CH_GT;
            2:       ch = CH_AMP;
            default: ch = 8'($urandom);
          endcase
          add_word(OP_TEXT, ch, run_style);
        end
      end
    end

    // reset once
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // wait for all words in and all bytes out, then watch for strays
    while (word_pending.size() != 0 || in_tvalid || html_expect.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && html_expect.size() == 0) begin
      $display("styled_text_html_serializer test passed");
    end else begin
      $display("styled_text_html_serializer test failed");
    end
    $finish;
  end

endmodule
